// ----- src/csma_pkg.sv -----
// shared types, codes and constants of the csma/ca channel access engine
package csma_pkg;

    localparam int DRAW_BITS = 16;
    localparam int DrawW     = 16;
    localparam logic [DrawW-1:0] DrawMask =
        (DRAW_BITS >= DrawW) ? {DrawW{1'b1}} : DrawW'((64'd1 << DRAW_BITS) - 64'd1);

    localparam logic [3:0]  MinExpReset  = 4'd10;
    localparam logic [3:0]  MaxExpReset  = 4'd5;
    localparam logic [3:0]  MaxBoReset   = 4'd4;
    localparam logic [15:0] UnitReset    = 16'd1;
    localparam logic [3:0]  BleExpCap    = 4'd2;
    localparam logic [1:0]  CwInit       = 2'd2;
    localparam logic [4:0]  NbMax        = 5'd31;

    typedef enum logic [2:0] {
        CFG_SLOTTED = 3'd0,
        CFG_BLE     = 3'd1,
        CFG_MIN_EXP = 3'd2,
        CFG_MAX_EXP = 3'd3,
        CFG_MAX_BO  = 3'd4,
        CFG_UNIT    = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_CANCEL = 2'd1,
        OP_TICK   = 2'd2,
        OP_CCA    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        NT_REQUEST = 2'd0,
        NT_IDLE    = 2'd1,
        NT_FAIL    = 2'd2,
        NT_CANCEL  = 2'd3
    } t_notice;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_BACKOFF = 3'b010,
        PH_CCA     = 3'b100
    } t_phase;

    typedef struct packed {
        logic        slotted;
        logic        ble;
        logic [3:0]  min_exp;
        logic [3:0]  max_exp;
        logic [3:0]  max_bo;
        logic [15:0] unit_ticks;
    } t_cfg;

    typedef struct packed {
        t_notice    notice;
        logic [4:0] retries;
    } t_result;

endpackage

// ----- src/csma_cfg.sv -----
// configuration register file of the channel access engine
module csma_cfg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_wdata,
    output csma_pkg::t_cfg     o_cfg
);

    csma_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slotted    <= 1'b0;
            r_cfg.ble        <= 1'b0;
            r_cfg.min_exp    <= csma_pkg::MinExpReset;
            r_cfg.max_exp    <= csma_pkg::MaxExpReset;
            r_cfg.max_bo     <= csma_pkg::MaxBoReset;
            r_cfg.unit_ticks <= csma_pkg::UnitReset;
        end else if (i_cfg_wr_en) begin
            unique case (csma_pkg::t_cfg_idx'(i_cfg_index))
                csma_pkg::CFG_SLOTTED: r_cfg.slotted    <= i_cfg_wdata[0];
                csma_pkg::CFG_BLE:     r_cfg.ble        <= i_cfg_wdata[0];
                csma_pkg::CFG_MIN_EXP: r_cfg.min_exp    <= i_cfg_wdata[3:0];
                csma_pkg::CFG_MAX_EXP: r_cfg.max_exp    <= i_cfg_wdata[3:0];
                csma_pkg::CFG_MAX_BO:  r_cfg.max_bo     <= i_cfg_wdata[3:0];
                csma_pkg::CFG_UNIT:    r_cfg.unit_ticks <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- src/csma_engine.sv -----
// backoff state registers and single-pass event update logic
module csma_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  csma_pkg::t_cfg      i_cfg,
    input  logic                i_accept,
    input  logic [1:0]          i_operation,
    input  logic                i_channel_clear,
    input  logic [15:0]         i_random_draw,
    output logic                o_res_valid,
    output csma_pkg::t_result   o_res
);

    logic [4:0]        r_nb, n_nb;
    logic [3:0]        r_be, n_be;
    logic [1:0]        r_cw, n_cw;
    logic [15:0]       r_slots, n_slots;
    logic [15:0]       r_ticks, n_ticks;
    csma_pkg::t_phase  r_phase, n_phase;

    logic [3:0]        be_start;
    logic [3:0]        be_busy;
    logic [3:0]        be_sel;
    logic [4:0]        be_inc;
    logic [4:0]        nb_inc;
    logic [1:0]        cw_dec;
    logic [15:0]       draw_slots;
    logic [15:0]       unit_len;
    csma_pkg::t_op     op;
    csma_pkg::t_notice notice;
    logic              res_valid;

    assign op       = csma_pkg::t_op'(i_operation);
    assign unit_len = (i_cfg.unit_ticks == 16'd0) ? 16'd1 : i_cfg.unit_ticks;
    assign be_start = (i_cfg.slotted && i_cfg.ble && i_cfg.min_exp > csma_pkg::BleExpCap)
                      ? csma_pkg::BleExpCap : i_cfg.min_exp;
    assign be_inc   = {1'b0, r_be} + 5'd1;
    assign be_busy  = (be_inc < {1'b0, i_cfg.max_exp}) ? be_inc[3:0] : i_cfg.max_exp;
    assign be_sel   = (op == csma_pkg::OP_START) ? be_start : be_busy;
    assign nb_inc   = (r_nb < csma_pkg::NbMax) ? r_nb + 5'd1 : r_nb;
    assign cw_dec   = (r_cw != 2'd0) ? r_cw - 2'd1 : 2'd0;
    assign draw_slots = i_random_draw & csma_pkg::DrawMask & ~(16'hFFFF << be_sel);

    always_comb begin
        n_nb      = r_nb;
        n_be      = r_be;
        n_cw      = r_cw;
        n_slots   = r_slots;
        n_ticks   = r_ticks;
        n_phase   = r_phase;
        res_valid = 1'b0;
        notice    = csma_pkg::NT_REQUEST;
        if (i_accept) begin
            unique case (op)
                csma_pkg::OP_START: begin
                    n_nb = 5'd0;
                    n_be = be_start;
                    if (i_cfg.slotted) begin
                        n_cw = csma_pkg::CwInit;
                    end
                    if (draw_slots == 16'd0) begin
                        n_phase   = csma_pkg::PH_CCA;
                        res_valid = 1'b1;
                    end else begin
                        n_slots = draw_slots;
                        n_ticks = unit_len;
                        n_phase = csma_pkg::PH_BACKOFF;
                    end
                end
                csma_pkg::OP_CANCEL: begin
                    n_phase   = csma_pkg::PH_IDLE;
                    n_slots   = 16'd0;
                    n_ticks   = 16'd0;
                    res_valid = 1'b1;
                    notice    = csma_pkg::NT_CANCEL;
                end
                csma_pkg::OP_TICK: begin
                    if (r_phase == csma_pkg::PH_BACKOFF) begin
                        if (r_ticks > 16'd1) begin
                            n_ticks = r_ticks - 16'd1;
                        end else if (r_slots > 16'd1) begin
                            n_slots = r_slots - 16'd1;
                            n_ticks = unit_len;
                        end else begin
                            n_slots   = 16'd0;
                            n_ticks   = 16'd0;
                            n_phase   = csma_pkg::PH_CCA;
                            res_valid = 1'b1;
                        end
                    end
                end
                csma_pkg::OP_CCA: begin
                    if (r_phase == csma_pkg::PH_CCA) begin
                        if (i_channel_clear) begin
                            res_valid = 1'b1;
                            if (i_cfg.slotted) begin
                                n_cw = cw_dec;
                            end
                            if (!(i_cfg.slotted && cw_dec != 2'd0)) begin
                                n_phase = csma_pkg::PH_IDLE;
                                notice  = csma_pkg::NT_IDLE;
                            end
                        end else begin
                            if (i_cfg.slotted) begin
                                n_cw = csma_pkg::CwInit;
                            end
                            n_be = be_busy;
                            n_nb = nb_inc;
                            if (nb_inc > {1'b0, i_cfg.max_bo}) begin
                                n_phase   = csma_pkg::PH_IDLE;
                                res_valid = 1'b1;
                                notice    = csma_pkg::NT_FAIL;
                            end else if (draw_slots == 16'd0) begin
                                n_phase   = csma_pkg::PH_CCA;
                                res_valid = 1'b1;
                            end else begin
                                n_slots = draw_slots;
                                n_ticks = unit_len;
                                n_phase = csma_pkg::PH_BACKOFF;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nb    <= 5'd0;
            r_be    <= 4'd0;
            r_cw    <= 2'd0;
            r_slots <= 16'd0;
            r_ticks <= 16'd0;
            r_phase <= csma_pkg::PH_IDLE;
        end else begin
            r_nb    <= n_nb;
            r_be    <= n_be;
            r_cw    <= n_cw;
            r_slots <= n_slots;
            r_ticks <= n_ticks;
            r_phase <= n_phase;
        end
    end

    assign o_res_valid    = res_valid;
    assign o_res.notice   = notice;
    assign o_res.retries  = n_nb;

endmodule

// ----- src/csma_obuf.sv -----
// result register with skid stage on the output channel
module csma_obuf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  csma_pkg::t_result   i_data,
    output logic                o_can_accept,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output csma_pkg::t_result   o_data
);

    logic              r_out_valid;
    logic              r_skid_valid;
    csma_pkg::t_result r_out;
    csma_pkg::t_result r_skid;
    logic              pop;

    assign pop = r_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else if (!i_push) begin
                r_out_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (i_push) begin
                r_out <= i_data;
            end
        end else if (i_push) begin
            if (!r_out_valid) begin
                r_out <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end
    end

    assign o_can_accept = !r_skid_valid;
    assign o_out_valid  = r_out_valid;
    assign o_data       = r_out;

endmodule

// ----- src/csma_ca_channel_access.sv -----
// top level of the csma/ca channel access engine
// results go to the output register, or to the skid stage while that is full
// throughput: one event per cycle while ready is high; backoff state updates in one pass
// input ready drops only while both output register and skid stage hold results
// synchronous active-low reset clears the backoff state, the result buffer and
// restores the configuration register defaults
module csma_ca_channel_access (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic        i_channel_clear,
    input  logic [15:0] i_random_draw,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_notice,
    output logic [4:0]  o_retries_used
);

    csma_pkg::t_cfg    cfg;
    csma_pkg::t_result res;
    csma_pkg::t_result out_data;
    logic              res_valid;
    logic              accept;

    assign accept = i_in_valid && o_in_ready;

    csma_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    csma_engine u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_accept        (accept),
        .i_operation     (i_operation),
        .i_channel_clear (i_channel_clear),
        .i_random_draw   (i_random_draw),
        .o_res_valid     (res_valid),
        .o_res           (res)
    );

    csma_obuf u_obuf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (res_valid),
        .i_data       (res),
        .o_can_accept (o_in_ready),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_data       (out_data)
    );

    assign o_notice       = out_data.notice;
    assign o_retries_used = out_data.retries;

    a_stall_implies_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result pending");

    a_cancel_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_operation == csma_pkg::OP_CANCEL |=> o_out_valid)
        else $error("cancel transaction produced no result");

    a_cancel_notice: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_operation == csma_pkg::OP_CANCEL && (!o_out_valid || i_out_ready)
        |=> o_notice == csma_pkg::NT_CANCEL)
        else $error("cancel result carries wrong notice");

    a_result_not_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("pending result dropped");

endmodule
